// ----- hdl/t4wk_pkg.sv -----
// ----------------------------------------------------------------------------
// t4wk_pkg
// Shared types and constants for the four-slot bone weight keeper.
// ----------------------------------------------------------------------------
package t4wk_pkg;

  localparam int VERTEX_COUNT = 4096;
  localparam int SLOTS        = 4;
  localparam int VIDX_W       = 12;
  localparam int BONE_W       = 8;
  localparam int WEIGHT_W     = 16;
  localparam int CNT_W        = 3;
  localparam int SLOT_W       = 2;
  // sum of four 16-bit weights
  localparam int SUM_W        = WEIGHT_W + SLOT_W;
  // partial remainder of the divider: always below twice the divisor
  localparam int REM_W        = SUM_W + 1;
  localparam int QUOT_W       = WEIGHT_W;
  localparam int STEP_W       = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

  // word opcodes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic [SLOTS-1:0][BONE_W-1:0]   bone;
    logic [SLOTS-1:0][WEIGHT_W-1:0] wt;
  } row_t;

endpackage

// ----- hdl/t4wk_div.sv -----
// ----------------------------------------------------------------------------
// t4wk_div
// Bit-serial restoring divider: quot = floor(num * 2^15 / den), num <= den.
// ----------------------------------------------------------------------------
module t4wk_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [t4wk_pkg::WEIGHT_W-1:0]     num,
  input  logic [t4wk_pkg::SUM_W-1:0]        den,
  output logic                              done,
  output logic [t4wk_pkg::QUOT_W-1:0]       quot
);

  logic                           active;
  logic [t4wk_pkg::STEP_W-1:0]    step;
  logic [t4wk_pkg::REM_W-1:0]     rem;
  logic [t4wk_pkg::SUM_W-1:0]     den_q;
  logic [t4wk_pkg::REM_W-1:0]     cand;
  logic [t4wk_pkg::REM_W-1:0]     diff;
  logic                           ge;

  // first step tests num >= den without a shift (integer bit of the quotient)
  assign cand = (step == '0) ? rem : {rem[t4wk_pkg::REM_W-2:0], 1'b0};
  assign ge   = cand >= {1'b0, den_q};
  assign diff = cand - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && step == {t4wk_pkg::STEP_W{1'b1}}) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step  <= '0;
      rem   <= {{(t4wk_pkg::REM_W-t4wk_pkg::WEIGHT_W){1'b0}}, num};
      den_q <= den;
      quot  <= '0;
    end else if (active) begin
      step <= step + 1'b1;
      rem  <= ge ? diff : cand;
      quot <= {quot[t4wk_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule

// ----- hdl/top4_weight_keep_normalize.sv -----
// ----------------------------------------------------------------------------
// top4_weight_keep_normalize
// Per-vertex store of up to four (bone, weight) pairs with normalized readout.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. After reset the block
// clears the fill counts of all 4096 vertices, one per cycle, and holds busy
// high until all of them are cleared. An add word that fills a free slot
// goes through fetch and write, and one with a zero weight ends after fetch.
// When the vertex is full, the smallest weight must be found by a
// one-compare-per-cycle scan, and the new pair replaces it only if its
// weight is larger. A read word of an empty vertex skips the divider;
// otherwise the weights are summed by one adder over the four slots, then
// each filled slot goes through a shared bit-serial divider that produces
// one quotient bit per cycle. The result appears on bone_out0..3 / share0..3
// with done high for exactly one cycle; there is no back-pressure, so the
// receiver must take it then. A read also resets that vertex's fill count,
// ready for the next mesh.
// ----------------------------------------------------------------------------
module top4_weight_keep_normalize (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [t4wk_pkg::VIDX_W-1:0]    vertex_index,
  input  logic [t4wk_pkg::BONE_W-1:0]    bone_id,
  input  logic [t4wk_pkg::WEIGHT_W-1:0]  weight,
  output logic                           done,
  output logic [t4wk_pkg::BONE_W-1:0]    bone_out0,
  output logic [t4wk_pkg::BONE_W-1:0]    bone_out1,
  output logic [t4wk_pkg::BONE_W-1:0]    bone_out2,
  output logic [t4wk_pkg::BONE_W-1:0]    bone_out3,
  output logic [t4wk_pkg::WEIGHT_W-1:0]  share0,
  output logic [t4wk_pkg::WEIGHT_W-1:0]  share1,
  output logic [t4wk_pkg::WEIGHT_W-1:0]  share2,
  output logic [t4wk_pkg::WEIGHT_W-1:0]  share3
);

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_WRITE    = 4'd5;
  localparam logic [3:0] S_SUM      = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  localparam logic [t4wk_pkg::SLOT_W-1:0] LAST_SLOT = 2'(t4wk_pkg::SLOTS - 1);
  localparam logic [t4wk_pkg::CNT_W-1:0]  FULL_CNT  = 3'(t4wk_pkg::SLOTS);
  localparam logic [t4wk_pkg::VIDX_W-1:0] LAST_VIDX = 12'(t4wk_pkg::VERTEX_COUNT - 1);

  logic [3:0] state;

  // latched input word
  logic                           op_q;
  logic [t4wk_pkg::VIDX_W-1:0]    vidx_q;
  logic [t4wk_pkg::BONE_W-1:0]    bone_q;
  logic [t4wk_pkg::WEIGHT_W-1:0]  weight_q;

  // working copy of the vertex entry
  t4wk_pkg::row_t                 slots;
  logic [t4wk_pkg::CNT_W-1:0]     cnt;
  logic [t4wk_pkg::CNT_W-1:0]     cnt_new;
  logic [t4wk_pkg::SLOT_W-1:0]    k;
  logic [t4wk_pkg::SLOT_W-1:0]    pick;
  logic [t4wk_pkg::SLOT_W-1:0]    tgt;
  logic [t4wk_pkg::SUM_W-1:0]     sum;
  logic [t4wk_pkg::SUM_W-1:0]     sum_add;
  logic [t4wk_pkg::WEIGHT_W-1:0]  shares [t4wk_pkg::SLOTS];
  logic [t4wk_pkg::VIDX_W-1:0]    clr_addr;

  // storage
  logic [t4wk_pkg::CNT_W-1:0]     cnt_mem [t4wk_pkg::VERTEX_COUNT];
  t4wk_pkg::row_t                 row_mem [t4wk_pkg::VERTEX_COUNT];
  logic [t4wk_pkg::CNT_W-1:0]     cnt_rd;
  t4wk_pkg::row_t                 row_rd;
  logic                           cnt_we;
  logic [t4wk_pkg::VIDX_W-1:0]    cnt_waddr;
  logic [t4wk_pkg::CNT_W-1:0]     cnt_wdata;
  logic                           row_we;
  t4wk_pkg::row_t                 row_wdata;

  logic                           accept;
  logic                           slot_filled;

  // shared divider
  logic                           div_start;
  logic                           div_done;
  logic [t4wk_pkg::QUOT_W-1:0]    div_quot;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // the slot under the scan / sum / divide pointer holds a live pair
  assign slot_filled = ({1'b0, k} < cnt);
  assign sum_add     = sum + (slot_filled ? {{t4wk_pkg::SLOT_W{1'b0}}, slots.wt[k]} : '0);

  // count store: cleared after reset, bumped by a fill, zeroed by a read
  assign cnt_we    = (state == S_CLEAR) || (state == S_WRITE) || (state == S_OUT);
  assign cnt_waddr = (state == S_CLEAR) ? clr_addr : vidx_q;
  assign cnt_wdata = (state == S_WRITE) ? cnt_new : '0;

  always_comb begin
    row_wdata          = slots;
    row_wdata.bone[tgt] = bone_q;
    row_wdata.wt[tgt]   = weight_q;
  end
  assign row_we = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd <= cnt_mem[vertex_index];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[vidx_q] <= row_wdata;
    end
    if (accept) begin
      row_rd <= row_mem[vertex_index];
    end
  end

  assign div_start = (state == S_DIV) && slot_filled;

  t4wk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (slots.wt[k]),
    .den   (sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_VIDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (op_q == t4wk_pkg::OP_READ) begin
            state <= S_SUM;
          end else if (weight_q == '0) begin
            state <= S_IDLE;
          end else if (cnt_rd < FULL_CNT) begin
            state <= S_WRITE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k == LAST_SLOT) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= (slots.wt[pick] < weight_q) ? S_WRITE : S_IDLE;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SUM: begin
          if (k == LAST_SLOT) begin
            state <= (sum_add == '0) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (slot_filled) begin
            state <= S_DIV_WAIT;
          end else if (k == LAST_SLOT) begin
            state <= S_OUT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= (k == LAST_SLOT) ? S_OUT : S_DIV;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q     <= op;
        vidx_q   <= vertex_index;
        bone_q   <= bone_id;
        weight_q <= weight;
      end
      S_FETCH: begin
        slots   <= row_rd;
        cnt     <= cnt_rd;
        cnt_new <= cnt_rd + 1'b1;
        tgt     <= cnt_rd[t4wk_pkg::SLOT_W-1:0];
        sum     <= '0;
        pick    <= '0;
        // the scan starts at slot 1, the sum at slot 0
        k       <= (op_q == t4wk_pkg::OP_READ) ? '0 : 2'd1;
      end
      S_SCAN: begin
        // strict compare keeps the first smallest weight
        if (slots.wt[k] < slots.wt[pick]) begin
          pick <= k;
        end
        k <= k + 1'b1;
      end
      S_DECIDE: begin
        tgt     <= pick;
        cnt_new <= cnt;
      end
      S_SUM: begin
        sum <= sum_add;
        k   <= k + 1'b1;
        if (k == LAST_SLOT && sum_add == '0) begin
          // empty vertex reads as full weight on slot 0
          shares[0] <= t4wk_pkg::WEIGHT_ONE;
          for (int i = 1; i < t4wk_pkg::SLOTS; i++) begin
            shares[i] <= '0;
          end
        end
      end
      S_DIV: begin
        if (!slot_filled) begin
          shares[k] <= '0;
          k         <= k + 1'b1;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          shares[k] <= div_quot;
          k         <= k + 1'b1;
        end
      end
      S_OUT: begin
        bone_out0 <= (cnt > 3'd0) ? slots.bone[0] : '0;
        bone_out1 <= (cnt > 3'd1) ? slots.bone[1] : '0;
        bone_out2 <= (cnt > 3'd2) ? slots.bone[2] : '0;
        bone_out3 <= (cnt > 3'd3) ? slots.bone[3] : '0;
        share0    <= shares[0];
        share1    <= shares[1];
        share2    <= shares[2];
        share3    <= shares[3];
      end
      default: begin
      end
    endcase
  end

  // a result leaves only from the output state
  a_done_from_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT))
    else $error("done without output state");

  // truncated shares never add up past one
  a_share_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (({2'b0, share0} + {2'b0, share1} + {2'b0, share2} + {2'b0, share3})
              <= {2'b0, t4wk_pkg::WEIGHT_ONE}))
    else $error("normalized shares exceed one");

  // replacement scan only runs on a full vertex
  a_scan_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt == FULL_CNT))
    else $error("scan on a vertex with free slots");

  // divider answers only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider done outside wait state");

endmodule
